// ----- design/stop_and_wait_data_receiver_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the stop-and-wait data receiver
// Shared property forms for the checker; each use sits on a line of its own.
// ---------------------------------------------------------------------------
`ifndef STOP_AND_WAIT_DATA_RECEIVER_DEFINES_SVH
`define STOP_AND_WAIT_DATA_RECEIVER_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted
`define SWDR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define SWDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/swdr_pkg.sv -----
// ---------------------------------------------------------------------------
// Stop-and-wait data receiver package
// Beat types, codes and fixed protocol constants shared by all modules.
// ---------------------------------------------------------------------------
package swdr_pkg;

    localparam logic [63:0] FIRST_NUMBER      = 64'd0;
    localparam logic [63:0] PREV_OF_FIRST     = FIRST_NUMBER - 64'd1;
    localparam logic [15:0] HEADER_BYTES      = 16'd21;
    localparam logic [15:0] CONN_BYTES        = 16'd17;
    localparam logic [15:0] DATA_PACKET_BYTES = 16'd64021;

    localparam logic [7:0]  KIND_CONN = 8'd1;
    localparam logic [7:0]  KIND_DATA = 8'd4;
    localparam logic [7:0]  RETRY_MAX = 8'd255;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_PACKET  = 2'd1,
        REQ_TIMEOUT = 2'd2
    } req_kind_t;

    typedef enum logic [2:0] {
        ACT_CONACC = 3'd0,
        ACT_ACC    = 3'd1,
        ACT_RJT    = 3'd2,
        ACT_CONRJT = 3'd3,
        ACT_STATUS = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_WAITING  = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_FAILED   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_DONE = 2'd2,
        PH_FAIL = 2'd3
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CLIENT_IP     = 3'd0,
        CFG_CLIENT_PORT   = 3'd1,
        CFG_SESSION_IDENT = 3'd2,
        CFG_TOTAL_LEN     = 3'd3,
        CFG_MIN_PAYLOAD   = 3'd4,
        CFG_MAX_PAYLOAD   = 3'd5,
        CFG_MAX_RETRIES   = 3'd6
    } cfg_addr_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] src_ip;
        logic [15:0] src_port;
        logic [15:0] pkt_len;
        logic [7:0]  pkt_kind;
        logic [63:0] pkt_session;
        logic [63:0] pkt_number;
        logic [31:0] payload_bytes;
    } req_t;

    typedef struct packed {
        action_t     action;
        logic [63:0] reply_number;
        logic [63:0] reply_session;
        status_t     phase_out;
    } rsp_t;

    typedef struct packed {
        logic [31:0] client_ip;
        logic [15:0] client_port;
        logic [63:0] session_ident;
        logic [63:0] total_len;
        logic [15:0] min_payload;
        logic [15:0] max_payload;
        logic [7:0]  max_retries;
    } cfg_t;

    // prev_number tracks expected_number - 1 so duplicates and resent ACCs
    // need no extra subtractor
    typedef struct packed {
        phase_t      phase;
        logic [63:0] expected_number;
        logic [63:0] prev_number;
        logic [63:0] bytes_received;
        logic [7:0]  retry_count;
    } state_t;

endpackage

// ----- design/swdr_eval.sv -----
// ---------------------------------------------------------------------------
// Stop-and-wait receiver event evaluation
// Next-state and reply logic for one event beat against the current state.
// ---------------------------------------------------------------------------
module swdr_eval
    import swdr_pkg::*;
(
    input  req_t   req,
    input  cfg_t   cfg,
    input  state_t cur,
    output state_t nxt,
    output logic   has_result,
    output rsp_t   rsp
);

    logic        foreign;
    logic        conn_shape;
    logic [32:0] len_sum;
    logic [64:0] total_sum;
    logic        overflow;
    logic        bad;
    logic [7:0]  retry_inc;

    assign foreign    = (req.src_ip != cfg.client_ip) || (req.src_port != cfg.client_port);
    assign conn_shape = (req.pkt_len == CONN_BYTES) && (req.pkt_kind == KIND_CONN);
    assign len_sum    = {1'b0, req.payload_bytes} + {17'd0, HEADER_BYTES};
    assign total_sum  = {1'b0, cur.bytes_received} + {33'd0, req.payload_bytes};
    // compare without wrap: 65-bit sum against the expected total
    assign overflow   = total_sum > {1'b0, cfg.total_len};
    assign bad        = (req.pkt_len < HEADER_BYTES)
                     || ({17'd0, req.pkt_len} != len_sum)
                     || (req.pkt_session != cfg.session_ident)
                     || (req.pkt_kind != KIND_DATA)
                     || overflow
                     || (req.payload_bytes < {16'd0, cfg.min_payload})
                     || (req.payload_bytes > {16'd0, cfg.max_payload});
    assign retry_inc  = (cur.retry_count == RETRY_MAX) ? RETRY_MAX : cur.retry_count + 8'd1;

    always_comb
    begin
        nxt                = cur;
        has_result         = 1'b0;
        rsp.action         = ACT_STATUS;
        rsp.reply_number   = 64'd0;
        rsp.reply_session  = cfg.session_ident;
        rsp.phase_out      = ST_WAITING;

        case (req_kind_t'(req.req_type))
            REQ_START:
            begin
                nxt.phase           = PH_WAIT;
                nxt.expected_number = FIRST_NUMBER;
                nxt.prev_number     = PREV_OF_FIRST;
                nxt.bytes_received  = 64'd0;
                nxt.retry_count     = 8'd0;
                has_result          = 1'b1;
                rsp.action          = ACT_CONACC;
            end
            REQ_PACKET:
            begin
                if (cur.phase == PH_WAIT)
                begin
                    if (foreign)
                    begin
                        // answer the stranger, leave the transfer alone
                        rsp.reply_session = req.pkt_session;
                        if (conn_shape)
                        begin
                            has_result = 1'b1;
                            rsp.action = ACT_CONRJT;
                        end
                        else if (req.pkt_len == DATA_PACKET_BYTES)
                        begin
                            has_result       = 1'b1;
                            rsp.action       = ACT_RJT;
                            rsp.reply_number = cur.expected_number;
                        end
                    end
                    else if (cur.expected_number == FIRST_NUMBER && conn_shape)
                    begin
                        // repeated CONN from our client: drop
                    end
                    else if (bad || (req.pkt_number != cur.expected_number
                                     && req.pkt_number != cur.prev_number))
                    begin
                        nxt.phase        = PH_FAIL;
                        has_result       = 1'b1;
                        rsp.action       = ACT_RJT;
                        rsp.reply_number = cur.expected_number;
                        rsp.phase_out    = ST_FAILED;
                    end
                    else if (req.pkt_number == cur.expected_number)
                    begin
                        nxt.bytes_received  = total_sum[63:0];
                        nxt.expected_number = cur.expected_number + 64'd1;
                        nxt.prev_number     = cur.expected_number;
                        nxt.retry_count     = 8'd0;
                        has_result          = 1'b1;
                        rsp.action          = ACT_ACC;
                        rsp.reply_number    = req.pkt_number;
                        if (total_sum[63:0] == cfg.total_len)
                        begin
                            nxt.phase     = PH_DONE;
                            rsp.phase_out = ST_COMPLETE;
                        end
                    end
                    // otherwise a duplicate of the last good packet: drop
                end
            end
            REQ_TIMEOUT:
            begin
                if (cur.phase == PH_WAIT)
                begin
                    nxt.retry_count = retry_inc;
                    has_result      = 1'b1;
                    if (retry_inc >= cfg.max_retries)
                    begin
                        nxt.phase     = PH_FAIL;
                        rsp.action    = ACT_STATUS;
                        rsp.phase_out = ST_FAILED;
                    end
                    else if (cur.expected_number == FIRST_NUMBER)
                    begin
                        rsp.action = ACT_CONACC;
                    end
                    else
                    begin
                        rsp.action       = ACT_ACC;
                        rsp.reply_number = cur.prev_number;
                    end
                end
            end
            default:
            begin
                // unknown event code: drop
            end
        endcase
    end

endmodule

// ----- design/stop_and_wait_data_receiver.sv -----
// ---------------------------------------------------------------------------
// Stop-and-wait data receiver
// Receiver side of a stop-and-wait transfer: header checks, ACK/reject replies.
// ---------------------------------------------------------------------------
// One event beat is taken every clock cycle while the input register is not
// held. A beat sits in the input register while the evaluation logic checks
// it and updates the transfer state, and its reply (if any) is then loaded
// into the result register, which drives rsp_valid and rsp_data. The input
// register is held only while it carries a beat with a reply and the result
// register is full and stalled; beats with no reply pass regardless. The
// configuration port is always ready; write it only while no beat is in
// flight. There is no clearing pass after reset.
module stop_and_wait_data_receiver
    import swdr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  req_t                   req_data,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output rsp_t                   rsp_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data
);

    logic   s1_valid_reg;
    req_t   s1_data_reg;
    state_t state_reg;
    state_t state_next;
    cfg_t   cfg_reg;
    logic   rsp_valid_reg;
    rsp_t   rsp_data_reg;
    logic   has_result;
    rsp_t   rsp_next;
    logic   out_free;
    logic   s1_retire;
    logic   req_accept;

    swdr_eval u_eval (
        .req        (s1_data_reg),
        .cfg        (cfg_reg),
        .cur        (state_reg),
        .nxt        (state_next),
        .has_result (has_result),
        .rsp        (rsp_next)
    );

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign s1_retire  = s1_valid_reg && (!has_result || out_free);
    assign req_stall  = s1_valid_reg && !s1_retire;
    assign req_accept = req_valid && !req_stall;
    assign cfg_ready  = 1'b1;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp_data   = rsp_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            state_reg.phase           <= PH_IDLE;
            state_reg.expected_number <= FIRST_NUMBER;
            state_reg.prev_number     <= PREV_OF_FIRST;
            state_reg.bytes_received  <= 64'd0;
            state_reg.retry_count     <= 8'd0;
        end
        else
        begin
            if (req_accept)
                s1_valid_reg <= 1'b1;
            else if (s1_retire)
                s1_valid_reg <= 1'b0;

            if (s1_retire)
                state_reg <= state_next;

            // load a new reply, or drop the one just taken
            if (s1_retire && has_result)
                rsp_valid_reg <= 1'b1;
            else if (out_free)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
            s1_data_reg <= req_data;
        if (s1_retire && has_result)
            rsp_data_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.client_ip     <= 32'd0;
            cfg_reg.client_port   <= 16'd0;
            cfg_reg.session_ident <= 64'd0;
            cfg_reg.total_len     <= 64'd0;
            cfg_reg.min_payload   <= 16'd1;
            cfg_reg.max_payload   <= 16'd64000;
            cfg_reg.max_retries   <= 8'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr_t'(cfg_index))
                CFG_CLIENT_IP:     cfg_reg.client_ip     <= cfg_data[31:0];
                CFG_CLIENT_PORT:   cfg_reg.client_port   <= cfg_data[15:0];
                CFG_SESSION_IDENT: cfg_reg.session_ident <= cfg_data;
                CFG_TOTAL_LEN:     cfg_reg.total_len     <= cfg_data;
                CFG_MIN_PAYLOAD:   cfg_reg.min_payload   <= cfg_data[15:0];
                CFG_MAX_PAYLOAD:   cfg_reg.max_payload   <= cfg_data[15:0];
                CFG_MAX_RETRIES:   cfg_reg.max_retries   <= cfg_data[7:0];
                default:
                begin
                    // unmapped index: drop the write
                end
            endcase
        end
    end

endmodule

// ----- design/swdr_checker.sv -----
// ---------------------------------------------------------------------------
// Stop-and-wait receiver port checker
// Watches the top-level ports for reply consistency and result beat holding.
// ---------------------------------------------------------------------------
`include "stop_and_wait_data_receiver_defines.svh"

module swdr_checker
    import swdr_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_stall,
    input logic rsp_valid,
    input logic rsp_stall,
    input rsp_t rsp_data
);

    logic rsp_held;
    logic is_status;
    logic is_conacc;
    logic is_conrjt;
    logic failed_out;
    logic plain_out;

    assign rsp_held   = rsp_valid && rsp_stall;
    assign is_status  = rsp_valid && (rsp_data.action == ACT_STATUS);
    assign is_conacc  = rsp_valid && (rsp_data.action == ACT_CONACC);
    assign is_conrjt  = rsp_valid && (rsp_data.action == ACT_CONRJT);
    assign failed_out = (rsp_data.phase_out == ST_FAILED);
    assign plain_out  = (rsp_data.reply_number == 64'd0) && (rsp_data.phase_out == ST_WAITING);

    // a stalled result beat holds
    `SWDR_ASSERT_NEXT(a_hold, clk, rst_n, rsp_held, rsp_valid && $stable(rsp_data), "beat changed")

    // a bare status beat only reports a failed transfer
    `SWDR_ASSERT_IMPLY(a_status_fail, clk, rst_n, is_status, failed_out, "status without failure")

    // CONACC carries no number and never ends the transfer
    `SWDR_ASSERT_IMPLY(a_conacc_form, clk, rst_n, is_conacc, plain_out, "malformed CONACC")

    // CONRJT goes to a stranger and leaves the phase alone
    `SWDR_ASSERT_IMPLY(a_conrjt_form, clk, rst_n, is_conrjt, plain_out, "malformed CONRJT")

    // the input only backs up behind a held result beat
    `SWDR_ASSERT_IMPLY(a_stall_cause, clk, rst_n, req_stall, rsp_held, "input stalled, output free")

endmodule

bind stop_and_wait_data_receiver swdr_checker u_swdr_checker (.*);
